/* sv/kmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pkg: shared types for the stream matcher
// Item modes, controller states, and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package kmp_pkg;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_TEXT   = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_TEST,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic walk_needed;
		logic fall_back;
		logic out_free;
	} sts_t;

endpackage

/* sv/kmp_sym_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_sym_if: input item channel
// Carries one pattern, text or clear item per transfer.
// ----------------------------------------------------------------------------
interface kmp_sym_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

/* sv/kmp_rep_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_rep_if: result channel
// Carries one match report per transfer.
// ----------------------------------------------------------------------------
interface kmp_rep_if;
	logic        valid;
	logic        ready;
	logic        match_found;
	logic [31:0] match_start;
	logic        pattern_overflow;

	modport source (output valid, output match_found, output match_start,
		output pattern_overflow, input ready);
	modport sink (input valid, input match_found, input match_start,
		input pattern_overflow, output ready);
endinterface

/* sv/kmp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_ctrl: matcher sequencer
// Accepts an item, runs the failure walk one lookup and one compare at a
// time, then commits the item and hands its result to the output register.
// ----------------------------------------------------------------------------
module kmp_ctrl import kmp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   sym_valid,
	output logic   sym_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		sym_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				sym_ready = 1'b1;
				if (sym_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.walk_needed ? S_LOOKUP : S_FINISH;
				end
			end
			S_LOOKUP: begin
				state_d = S_TEST;
			end
			S_TEST: begin
				cmd.step = 1'b1;
				state_d  = sts.fall_back ? S_LOOKUP : S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* sv/kmp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_dp: matcher datapath
// Pattern and failure memories, the walk register, match progress, text
// position and the output register.
// ----------------------------------------------------------------------------
module kmp_dp import kmp_pkg::*; #(
	parameter int PATTERN_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        rep_valid,
	input  logic        rep_ready,
	output logic        match_found,
	output logic [31:0] match_start,
	output logic        pattern_overflow
);

	localparam int IW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int LW = $clog2(PATTERN_DEPTH + 1);

	logic [7:0]    pat_mem [PATTERN_DEPTH];
	logic [IW-1:0] fail_mem [PATTERN_DEPTH];
	logic [7:0]    pat_rd_q;
	logic [IW-1:0] fail_rd_q;

	logic [1:0]    mode_q;
	logic [7:0]    byte_q;
	logic [LW-1:0] walk_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] matched_q;
	logic [IW-1:0] last_fail_q;
	logic [31:0]   pos_q;

	logic          out_valid_q;
	logic          found_q;
	logic [31:0]   start_q;
	logic          overflow_q;

	logic          len_zero;
	logic          len_full;
	logic          hit;
	logic [IW-1:0] pat_addr;
	logic [IW-1:0] fail_addr;

	assign len_zero  = (len_q == '0);
	assign len_full  = (len_q == LW'(PATTERN_DEPTH));
	assign hit       = !len_zero && (walk_q == len_q);
	assign pat_addr  = walk_q[IW-1:0];
	assign fail_addr = IW'(walk_q - LW'(1));

	assign sts.walk_needed = !len_zero &&
		((mode == MODE_TEXT) || ((mode == MODE_APPEND) && !len_full));
	assign sts.fall_back   = (walk_q != '0) && (pat_rd_q != byte_q);
	assign sts.out_free    = !out_valid_q || rep_ready;

	always_ff @(posedge clk) begin
		pat_rd_q  <= pat_mem[pat_addr];
		fail_rd_q <= fail_mem[fail_addr];
		if (cmd.commit && (mode_q == MODE_APPEND) && !len_full) begin
			pat_mem[len_q[IW-1:0]]  <= byte_q;
			fail_mem[len_q[IW-1:0]] <= walk_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			byte_q <= data_byte;
			if ((mode == MODE_APPEND) && !len_zero) begin
				walk_q <= LW'(last_fail_q);
			end else if (mode == MODE_TEXT) begin
				walk_q <= matched_q;
			end else begin
				walk_q <= '0;
			end
		end else if (cmd.step) begin
			if (sts.fall_back) begin
				walk_q <= LW'(fail_rd_q);
			end else if (pat_rd_q == byte_q) begin
				walk_q <= walk_q + LW'(1);
			end
		end
		if (cmd.commit && (mode_q == MODE_APPEND) && !len_full) begin
			last_fail_q <= walk_q[IW-1:0];
		end
		if (cmd.commit) begin
			found_q    <= (mode_q == MODE_TEXT) && hit;
			start_q    <= ((mode_q == MODE_TEXT) && hit) ?
				(pos_q + 32'd1 - 32'(len_q)) : 32'd0;
			overflow_q <= (mode_q == MODE_APPEND) && len_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			matched_q   <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rep_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				case (mode_q)
					MODE_APPEND: begin
						if (!len_full) begin
							len_q <= len_q + LW'(1);
						end
						matched_q <= '0;
						pos_q     <= '0;
					end
					MODE_TEXT: begin
						if (!len_zero) begin
							matched_q <= hit ? LW'(last_fail_q) : walk_q;
						end
						pos_q <= pos_q + 32'd1;
					end
					MODE_CLEAR: begin
						len_q     <= '0;
						matched_q <= '0;
						pos_q     <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign rep_valid        = out_valid_q;
	assign match_found      = found_q;
	assign match_start      = start_q;
	assign pattern_overflow = overflow_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(PATTERN_DEPTH))
		else $error("pattern length beyond store depth");

	a_progress_empty: assert property (@(posedge clk) disable iff (!arst_n)
		len_zero |-> (matched_q == '0))
		else $error("match progress held with an empty pattern");

	a_progress_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!len_zero |-> (matched_q < len_q))
		else $error("match progress reached the pattern length");

	a_commit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed item left no result");

endmodule

/* sv/kmp_stream_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_stream_matcher: streaming Knuth-Morris-Pratt exact matcher
// Pattern bytes are appended, text bytes are scanned, and every occurrence
// is reported with its start offset in the text.
// ----------------------------------------------------------------------------
// An item that needs no failure walk goes from the idle state straight to finish.
// A text byte or an appended byte against a non-empty pattern walks the failure
// chain. The first compare passes through one lookup state and one test state,
// since the pattern and failure memories have registered read ports, and each
// fallback step passes through both again. Over a text stream the number of
// fallbacks averages below one per byte. A clear, an unused mode, a dropped
// pattern byte, the first pattern byte or a byte against an empty pattern
// never walks the chain. A new item is accepted while the previous result still
// waits in the output register, and its commit then waits until that result has
// transferred.
module kmp_stream_matcher import kmp_pkg::*; #(
	parameter int PATTERN_DEPTH = 128
) (
	input logic          clk,
	input logic          arst_n,
	kmp_sym_if.sink      symbol,
	kmp_rep_if.source    report
);

	cmd_t cmd;
	sts_t sts;

	kmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (symbol.valid),
		.sym_ready (symbol.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kmp_dp #(
		.PATTERN_DEPTH (PATTERN_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.mode             (symbol.mode),
		.data_byte        (symbol.data_byte),
		.cmd              (cmd),
		.sts              (sts),
		.rep_valid        (report.valid),
		.rep_ready        (report.ready),
		.match_found      (report.match_found),
		.match_start      (report.match_start),
		.pattern_overflow (report.pattern_overflow)
	);

endmodule
